// File: src/pwa_pkg.sv
package pwa_pkg;

  localparam int DATA_W    = 64;
  localparam int MAX_WIDTH = 64;
  localparam int BASE_W    = 5;
  localparam int REQ_W     = 5;
  localparam int CUR_W     = 6;
  localparam int WBITS_W   = 7;
  localparam int STATUS_W  = 3;

  // The divider retires one hex digit of the dividend per cycle.
  localparam int DIV_DIGIT  = 4;
  localparam int DIV_STEPS  = DATA_W / DIV_DIGIT;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  localparam logic [BASE_W-1:0] BASE_RESET = BASE_W'(10);

  // Command codes.
  localparam logic [REQ_W-1:0] REQ_DIGIT   = REQ_W'(0);
  localparam logic [REQ_W-1:0] REQ_DELETE  = REQ_W'(1);
  localparam logic [REQ_W-1:0] REQ_CLEAR   = REQ_W'(2);
  localparam logic [REQ_W-1:0] REQ_LOAD    = REQ_W'(3);
  localparam logic [REQ_W-1:0] REQ_WIDTH   = REQ_W'(4);
  localparam logic [REQ_W-1:0] REQ_CURSOR  = REQ_W'(5);
  localparam logic [REQ_W-1:0] REQ_SETOP   = REQ_W'(6);
  localparam logic [REQ_W-1:0] REQ_EQUALS  = REQ_W'(7);
  localparam logic [REQ_W-1:0] REQ_SHL     = REQ_W'(8);
  localparam logic [REQ_W-1:0] REQ_SHR     = REQ_W'(9);
  localparam logic [REQ_W-1:0] REQ_NOT     = REQ_W'(10);
  localparam logic [REQ_W-1:0] REQ_NEG     = REQ_W'(11);
  localparam logic [REQ_W-1:0] REQ_ROL     = REQ_W'(12);
  localparam logic [REQ_W-1:0] REQ_ROR     = REQ_W'(13);
  localparam logic [REQ_W-1:0] REQ_SWAP    = REQ_W'(14);
  localparam logic [REQ_W-1:0] REQ_INC     = REQ_W'(15);
  localparam logic [REQ_W-1:0] REQ_DEC     = REQ_W'(16);
  localparam logic [REQ_W-1:0] REQ_SETBIT  = REQ_W'(17);
  localparam logic [REQ_W-1:0] REQ_CLRBIT  = REQ_W'(18);
  localparam logic [REQ_W-1:0] REQ_TGLBIT  = REQ_W'(19);
  localparam logic [REQ_W-1:0] REQ_CLRFLAG = REQ_W'(20);

  // Pending logic operations.
  localparam logic [1:0] LOP_NONE = 2'd0;
  localparam logic [1:0] LOP_AND  = 2'd1;
  localparam logic [1:0] LOP_OR   = 2'd2;
  localparam logic [1:0] LOP_XOR  = 2'd3;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK        = STATUS_W'(0);
  localparam logic [STATUS_W-1:0] ST_BAD_DIGIT = STATUS_W'(1);
  localparam logic [STATUS_W-1:0] ST_ENTRY_OVF = STATUS_W'(2);
  localparam logic [STATUS_W-1:0] ST_BAD_WIDTH = STATUS_W'(3);
  localparam logic [STATUS_W-1:0] ST_NO_OP     = STATUS_W'(4);

  typedef struct packed {
    logic load;       // capture the accepted beat
    logic div_start;  // launch the base divider
    logic commit;     // update state and fill the result register
  } pwa_cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_done;
  } pwa_stat_t;

  typedef struct packed {
    logic                entry_fresh;
    logic [WBITS_W-1:0]  width_bits;
    logic [1:0]          op_pending;
    logic [CUR_W-1:0]    cursor_index;
    logic                cursor_bit;
    logic [STATUS_W-1:0] status;
    logic                overflow_flag;
    logic                carry_flag;
    logic [DATA_W-1:0]   acc_value;
  } pwa_result_t;

  // Largest of 8/16/32/64 that does not exceed MAX_WIDTH.
  function automatic logic [1:0] reset_wcode();
    logic [1:0] c;
    c = 2'd0;
    for (int i = 1; i < 4; i++) begin
      if ((8 << i) <= MAX_WIDTH) begin
        c = 2'(i);
      end
    end
    return c;
  endfunction

  function automatic logic [DATA_W-1:0] width_mask(input logic [1:0] code);
    logic [DATA_W-1:0] m;
    case (code)
      2'd0:    m = DATA_W'(64'h0000_0000_0000_00FF);
      2'd1:    m = DATA_W'(64'h0000_0000_0000_FFFF);
      2'd2:    m = DATA_W'(64'h0000_0000_FFFF_FFFF);
      default: m = '1;
    endcase
    return m;
  endfunction

endpackage

// File: src/pwa_div.sv
// Iterative divider: unsigned DATA_W-bit dividend by a BASE_W-bit divisor,
// one hex digit per cycle, restoring form. Divisor must be nonzero.
module pwa_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [pwa_pkg::DATA_W-1:0]    dividend,
  input  logic [pwa_pkg::BASE_W-1:0]    divisor,
  output logic                          done,
  output logic [pwa_pkg::DATA_W-1:0]    quotient
);

  logic                            busy;
  logic [pwa_pkg::DIV_CNT_W-1:0]   cnt;
  logic [pwa_pkg::DATA_W-1:0]      num;
  logic [pwa_pkg::DATA_W-1:0]      num_next;
  logic [pwa_pkg::BASE_W-1:0]      rem;
  logic [pwa_pkg::BASE_W-1:0]      rem_next;
  logic [pwa_pkg::BASE_W-1:0]      dvs;

  // Dividend bits leave at the top while quotient bits enter at the bottom.
  always_comb begin
    logic [pwa_pkg::BASE_W:0]        r;
    logic [pwa_pkg::DIV_DIGIT-1:0]   q;
    r = '0;
    q = '0;
    rem_next = rem;
    for (int k = 0; k < pwa_pkg::DIV_DIGIT; k++) begin
      r = {rem_next, num[pwa_pkg::DATA_W-1-k]};
      if (r >= {1'b0, dvs}) begin
        r = r - {1'b0, dvs};
        q[pwa_pkg::DIV_DIGIT-1-k] = 1'b1;
      end
      rem_next = r[pwa_pkg::BASE_W-1:0];
    end
    num_next = {num[pwa_pkg::DATA_W-pwa_pkg::DIV_DIGIT-1:0], q};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == pwa_pkg::DIV_CNT_W'(pwa_pkg::DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      num <= num_next;
      rem <= rem_next;
    end
  end

  assign quotient = num;

endmodule

// File: src/pwa_dp.sv
// Datapath: architectural state, command register, combinational word
// operations, the base divider for digit delete, and the result register.
module pwa_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [pwa_pkg::BASE_W-1:0]        cfg_data,
  input  pwa_pkg::pwa_cmd_t                 cmd,
  output pwa_pkg::pwa_stat_t                stat,
  input  logic [pwa_pkg::REQ_W-1:0]         req_type,
  input  logic [7:0]                        digit_char,
  input  logic [pwa_pkg::DATA_W-1:0]        load_value,
  input  logic signed [7:0]                 cursor_move,
  input  logic [pwa_pkg::WBITS_W-1:0]       width_request,
  input  logic [1:0]                        logic_op,
  output pwa_pkg::pwa_result_t              result
);

  // Captured command.
  logic [pwa_pkg::REQ_W-1:0]    c_req;
  logic [7:0]                   c_ch;
  logic [pwa_pkg::DATA_W-1:0]   c_load;
  logic [7:0]                   c_mv;
  logic [pwa_pkg::WBITS_W-1:0]  c_wreq;
  logic [1:0]                   c_lop;

  // Architectural state.
  logic [pwa_pkg::BASE_W-1:0]   base;
  logic [pwa_pkg::DATA_W-1:0]   acc;
  logic [pwa_pkg::DATA_W-1:0]   acc_next;
  logic [pwa_pkg::DATA_W-1:0]   left;
  logic [pwa_pkg::DATA_W-1:0]   left_next;
  logic [1:0]                   pend;
  logic [1:0]                   pend_next;
  logic                         fresh;
  logic                         fresh_next;
  logic [pwa_pkg::CUR_W-1:0]    cursor;
  logic [pwa_pkg::CUR_W-1:0]    cursor_next;
  logic                         carry;
  logic                         carry_next;
  logic                         ovf;
  logic                         ovf_next;
  logic [1:0]                   wcode;
  logic [1:0]                   wcode_next;
  logic [pwa_pkg::STATUS_W-1:0] status_next;

  logic [pwa_pkg::DATA_W-1:0]   quot;
  logic                         div_done;
  logic [pwa_pkg::DATA_W-1:0]   mask;
  logic [pwa_pkg::DATA_W-1:0]   v;

  assign mask = pwa_pkg::width_mask(wcode);
  assign v    = acc & mask;

  pwa_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (v),
    .divisor  (base),
    .done     (div_done),
    .quotient (quot)
  );

  assign stat.need_div = (c_req == pwa_pkg::REQ_DELETE) && !fresh && (base != '0);
  assign stat.div_done = div_done;

  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end
    return r;
  endfunction

  always_comb begin
    logic [pwa_pkg::DATA_W-1:0]  sign;
    logic                        msb;
    logic [pwa_pkg::DATA_W-1:0]  r;
    logic [pwa_pkg::DATA_W-1:0]  cur;
    logic [4:0]                  hd;
    logic [69:0]                 ent;
    logic [pwa_pkg::WBITS_W-1:0] wbits;
    logic [1:0]                  c;
    logic signed [8:0]           sel;
    logic [pwa_pkg::DATA_W-1:0]  bit_m;
    logic                        do_finish;

    sign  = (mask >> 1) + 1'b1;
    msb   = |(v & sign);
    wbits = pwa_pkg::WBITS_W'(8) << wcode;
    r     = '0;
    cur   = fresh ? '0 : v;
    hd    = hex_decode(c_ch);
    ent   = 70'(cur) * 70'(base) + 70'(hd[3:0]);
    c     = wcode;
    sel   = $signed({3'b000, cursor}) + $signed({c_mv[7], c_mv});
    bit_m = pwa_pkg::DATA_W'(1) << cursor;
    do_finish = 1'b0;

    acc_next    = acc;
    left_next   = left;
    pend_next   = pend;
    fresh_next  = fresh;
    cursor_next = cursor;
    carry_next  = carry;
    ovf_next    = ovf;
    wcode_next  = wcode;
    status_next = pwa_pkg::ST_OK;

    case (c_req)
      pwa_pkg::REQ_DIGIT: begin
        if (!hd[4] || ({1'b0, hd[3:0]} >= base)) begin
          status_next = pwa_pkg::ST_BAD_DIGIT;
        end else if (ent > 70'(mask)) begin
          ovf_next    = 1'b1;
          status_next = pwa_pkg::ST_ENTRY_OVF;
        end else begin
          acc_next   = ent[pwa_pkg::DATA_W-1:0];
          fresh_next = 1'b0;
          carry_next = 1'b0;
          ovf_next   = 1'b0;
        end
      end
      pwa_pkg::REQ_DELETE: begin
        if (!fresh && (base != '0)) begin
          acc_next = quot;
        end
      end
      pwa_pkg::REQ_CLEAR: begin
        acc_next    = '0;
        left_next   = '0;
        pend_next   = pwa_pkg::LOP_NONE;
        fresh_next  = 1'b1;
        cursor_next = '0;
        carry_next  = 1'b0;
        ovf_next    = 1'b0;
      end
      pwa_pkg::REQ_LOAD: begin
        carry_next = 1'b0;
        ovf_next   = 1'b0;
        r          = c_load;
        do_finish  = 1'b1;
      end
      pwa_pkg::REQ_WIDTH: begin
        if (c_wreq == 7'd8 && 8 <= pwa_pkg::MAX_WIDTH) begin
          c = 2'd0;
        end else if (c_wreq == 7'd16 && 16 <= pwa_pkg::MAX_WIDTH) begin
          c = 2'd1;
        end else if (c_wreq == 7'd32 && 32 <= pwa_pkg::MAX_WIDTH) begin
          c = 2'd2;
        end else if (c_wreq == 7'd64 && 64 <= pwa_pkg::MAX_WIDTH) begin
          c = 2'd3;
        end else begin
          status_next = pwa_pkg::ST_BAD_WIDTH;
        end
        if (status_next == pwa_pkg::ST_OK) begin
          wcode_next = c;
          if ({1'b0, cursor} >= c_wreq) begin
            cursor_next = pwa_pkg::CUR_W'(c_wreq - 1'b1);
          end
          acc_next   = acc & pwa_pkg::width_mask(c);
          left_next  = left & pwa_pkg::width_mask(c);
          carry_next = 1'b0;
          ovf_next   = 1'b0;
        end
      end
      pwa_pkg::REQ_CURSOR: begin
        if (sel < 0) begin
          cursor_next = '0;
        end else if (sel >= $signed({2'b00, wbits})) begin
          cursor_next = pwa_pkg::CUR_W'(wbits - 1'b1);
        end else begin
          cursor_next = sel[pwa_pkg::CUR_W-1:0];
        end
      end
      pwa_pkg::REQ_SETOP: begin
        left_next  = v;
        pend_next  = c_lop;
        acc_next   = '0;
        fresh_next = 1'b1;
      end
      pwa_pkg::REQ_EQUALS: begin
        case (pend)
          pwa_pkg::LOP_AND: r = left & v;
          pwa_pkg::LOP_OR:  r = left | v;
          default:          r = left ^ v;
        endcase
        if (pend == pwa_pkg::LOP_NONE) begin
          status_next = pwa_pkg::ST_NO_OP;
        end else begin
          carry_next = 1'b0;
          ovf_next   = 1'b0;
          pend_next  = pwa_pkg::LOP_NONE;
          do_finish  = 1'b1;
        end
      end
      pwa_pkg::REQ_SHL: begin
        carry_next = msb;
        ovf_next   = 1'b0;
        r          = v << 1;
        do_finish  = 1'b1;
      end
      pwa_pkg::REQ_SHR: begin
        carry_next = v[0];
        ovf_next   = 1'b0;
        r          = v >> 1;
        do_finish  = 1'b1;
      end
      pwa_pkg::REQ_NOT: begin
        carry_next = 1'b0;
        ovf_next   = 1'b0;
        r          = ~v;
        do_finish  = 1'b1;
      end
      pwa_pkg::REQ_NEG: begin
        carry_next = (v != '0);
        ovf_next   = (v == sign);
        r          = ~v + 1'b1;
        do_finish  = 1'b1;
      end
      pwa_pkg::REQ_ROL: begin
        carry_next = msb;
        ovf_next   = 1'b0;
        r          = (v << 1) | pwa_pkg::DATA_W'(msb);
        do_finish  = 1'b1;
      end
      pwa_pkg::REQ_ROR: begin
        carry_next = v[0];
        ovf_next   = 1'b0;
        r          = (v >> 1) | (v[0] ? sign : '0);
        do_finish  = 1'b1;
      end
      pwa_pkg::REQ_SWAP: begin
        // Reverse the bytes inside the active width.
        case (wcode)
          2'd0: r = v;
          2'd1: r = {48'b0, v[7:0], v[15:8]};
          2'd2: r = {32'b0, v[7:0], v[15:8], v[23:16], v[31:24]};
          default: begin
            for (int i = 0; i < 8; i++) begin
              r[8*i +: 8] = v[8*(7-i) +: 8];
            end
          end
        endcase
        carry_next = 1'b0;
        ovf_next   = 1'b0;
        do_finish  = 1'b1;
      end
      pwa_pkg::REQ_INC: begin
        carry_next = (v == mask);
        ovf_next   = (v == sign - 1'b1);
        r          = v + 1'b1;
        do_finish  = 1'b1;
      end
      pwa_pkg::REQ_DEC: begin
        carry_next = (v != '0);
        ovf_next   = (v == sign);
        r          = v - 1'b1;
        do_finish  = 1'b1;
      end
      pwa_pkg::REQ_SETBIT: begin
        carry_next = 1'b0;
        ovf_next   = 1'b0;
        r          = v | bit_m;
        do_finish  = 1'b1;
      end
      pwa_pkg::REQ_CLRBIT: begin
        carry_next = 1'b0;
        ovf_next   = 1'b0;
        r          = v & ~bit_m;
        do_finish  = 1'b1;
      end
      pwa_pkg::REQ_TGLBIT: begin
        carry_next = 1'b0;
        ovf_next   = 1'b0;
        r          = v ^ bit_m;
        do_finish  = 1'b1;
      end
      pwa_pkg::REQ_CLRFLAG: begin
        carry_next = 1'b0;
        ovf_next   = 1'b0;
      end
      default: begin
      end
    endcase

    if (do_finish) begin
      acc_next   = r & mask;
      fresh_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      c_req  <= req_type;
      c_ch   <= digit_char;
      c_load <= load_value;
      c_mv   <= cursor_move;
      c_wreq <= width_request;
      c_lop  <= logic_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base   <= pwa_pkg::BASE_RESET;
      acc    <= '0;
      left   <= '0;
      pend   <= pwa_pkg::LOP_NONE;
      fresh  <= 1'b1;
      cursor <= '0;
      carry  <= 1'b0;
      ovf    <= 1'b0;
      wcode  <= pwa_pkg::reset_wcode();
    end else begin
      if (cfg_we) begin
        base <= cfg_data;
      end
      if (cmd.commit) begin
        acc    <= acc_next;
        left   <= left_next;
        pend   <= pend_next;
        fresh  <= fresh_next;
        cursor <= cursor_next;
        carry  <= carry_next;
        ovf    <= ovf_next;
        wcode  <= wcode_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      result.acc_value     <= acc_next;
      result.carry_flag    <= carry_next;
      result.overflow_flag <= ovf_next;
      result.status        <= status_next;
      result.cursor_bit    <= acc_next[cursor_next];
      result.cursor_index  <= cursor_next;
      result.op_pending    <= pend_next;
      result.width_bits    <= pwa_pkg::WBITS_W'(8) << wcode_next;
      result.entry_fresh   <= fresh_next;
    end
  end

endmodule

// File: src/pwa_ctrl.sv
// Controller: accepts one command beat, runs the divider when a delete
// needs it, and commits into the result register once that register is free.
module pwa_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output pwa_pkg::pwa_cmd_t  cmd,
  input  pwa_pkg::pwa_stat_t stat
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_DECODE = 2'd1;
  localparam logic [1:0] S_DIVIDE = 2'd2;
  localparam logic [1:0] S_COMMIT = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_free;

  assign in_ready  = (state == S_IDLE);
  assign out_free  = !out_valid || out_ready;

  always_comb begin
    state_next    = state;
    cmd.load      = 1'b0;
    cmd.div_start = 1'b0;
    cmd.commit    = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat.need_div) begin
          cmd.div_start = 1'b1;
          state_next    = S_DIVIDE;
        end else begin
          state_next = S_COMMIT;
        end
      end
      S_DIVIDE: begin
        if (stat.div_done) begin
          state_next = S_COMMIT;
        end
      end
      S_COMMIT: begin
        if (out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: src/programmer_word_alu.sv
// Flow: a command beat is captured and decoded; a digit delete that divides
//   then passes through the one-hex-digit-per-cycle base divider; the command
//   commits into the result register once it is free, raising the result beat.
// A new command beat is taken only after the previous command has committed.
// Reset: rst is synchronous and active high; it restores the power-on
//   state (base 10, 64-bit width, fresh entry) with no clearing pass.
module programmer_word_alu (
  input  logic        clk,
  input  logic        rst,
  // Command stream. The beat kind rides in tuser, the operands in tdata.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata from bit 0 up: digit_char[7:0], load_value[63:0], cursor_move[7:0]
  // (signed), width_request[6:0], logic_op[1:0], seven zero bits.
  input  logic [95:0] s_axis_tdata,
  // tuser: req_type[4:0].
  input  logic [4:0]  s_axis_tuser,
  // Result stream, one beat per command.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata from bit 0 up: acc_value[63:0], carry_flag, overflow_flag,
  // status[2:0], cursor_bit, cursor_index[5:0], op_pending[1:0],
  // width_bits[6:0], entry_fresh, two zero bits.
  output logic [87:0] m_axis_tdata,
  // Configuration write channel carrying number_base.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data
);

  pwa_pkg::pwa_cmd_t    cmd;
  pwa_pkg::pwa_stat_t   stat;
  pwa_pkg::pwa_result_t result;

  // The base register can always be written; the user only writes it
  // while no command is in flight.
  assign cfg_ready = 1'b1;

  // The controller sequences each command: capture, optional division,
  // then commit. Commit waits only on the result register, so a new
  // command beat is taken while the previous result still waits.
  pwa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // The datapath holds the accumulator state and does all the arithmetic.
  pwa_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_valid & cfg_ready),
    .cfg_data      (cfg_data),
    .cmd           (cmd),
    .stat          (stat),
    .req_type      (s_axis_tuser),
    .digit_char    (s_axis_tdata[7:0]),
    .load_value    (s_axis_tdata[71:8]),
    .cursor_move   (s_axis_tdata[79:72]),
    .width_request (s_axis_tdata[86:80]),
    .logic_op      (s_axis_tdata[88:87]),
    .result        (result)
  );

  assign m_axis_tdata = {2'b00,
                         result.entry_fresh,
                         result.width_bits,
                         result.op_pending,
                         result.cursor_index,
                         result.cursor_bit,
                         result.status,
                         result.overflow_flag,
                         result.carry_flag,
                         result.acc_value};

endmodule

// File: src/pwa_checker.sv
module pwa_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [87:0] m_axis_tdata
);

  logic [6:0] wbits;
  logic [5:0] cidx;

  assign wbits = m_axis_tdata[84:78];
  assign cidx  = m_axis_tdata[75:70];

  // Only one command is in flight: after a beat is taken, input closes.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while a command is in flight");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result beat changed");

  a_width_legal: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (wbits == 7'd8 || wbits == 7'd16 || wbits == 7'd32 ||
                       wbits == 7'd64))
    else $error("reported width is not 8, 16, 32 or 64");

  a_cursor_in_width: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> ({1'b0, cidx} < wbits))
    else $error("cursor outside the word width");

  a_cursor_bit: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[69] == m_axis_tdata[cidx]))
    else $error("cursor bit disagrees with the accumulator");

endmodule

bind programmer_word_alu pwa_checker u_pwa_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// File: dv/programmer_word_alu_tb.sv
`timescale 1ns / 100ps

module programmer_word_alu_tb;
  import pwa_pkg::*;

  // One command beat as the testbench sees it, before packing into tdata and tuser.
  typedef struct packed {
    logic [REQ_W-1:0]   req;
    logic [7:0]         ch;
    logic [DATA_W-1:0]  load;
    logic signed [7:0]  mv;
    logic [WBITS_W-1:0] wreq;
    logic [1:0]         lop;
  } word_cmd_t;

  localparam int LIMIT_CYCLES  = 400000;
  localparam int PHASE_ITEMS   = 230;
  localparam int SETTLE_CYCLES = 24;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata = '0;
  logic [4:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b1;
  logic [87:0] m_axis_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [4:0]  cfg_data = '0;

  // Commands waiting for the driver, and the reports predicted for accepted beats.
  word_cmd_t   command_fifo[$];
  pwa_result_t report_fifo[$];
  word_cmd_t   cmd_on_bus = '0;
  logic        beat_taken = 1'b0;
  bit          drain_hold = 1'b0;

  // Commands queued or in flight whose report has not been checked yet.
  int          open_commands = 0;
  int          commands_queued = 0;
  int          fail_count = 0;
  int          cycle_count = 0;
  int unsigned send_idle_pct = 6;
  int unsigned recv_idle_pct = 55;

  // Shadow copy of the word unit's architectural state.
  logic [DATA_W-1:0]  acc_q;
  logic [DATA_W-1:0]  left_q;
  logic [1:0]         pend_q;
  logic               fresh_q;
  logic [CUR_W-1:0]   cursor_q;
  logic               carry_q;
  logic               ovf_q;
  logic [1:0]         wcode_q;
  logic [BASE_W-1:0]  base_q;

  programmer_word_alu i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Timeout guard. A missing report leaves open_commands above zero forever, so it ends here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("%0t: timeout with %0d commands outstanding", $time, open_commands);
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic logic [DATA_W-1:0] mask_of(input int unsigned w);
    return (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
  endfunction

  // Most results are masked to the word width and restart digit entry.
  function automatic void settle(input logic [DATA_W-1:0] r, input logic [DATA_W-1:0] m);
    acc_q   = r & m;
    fresh_q = 1'b1;
  endfunction

  // Applies one command to the shadow state and returns the report it should produce.
  function automatic pwa_result_t apply_command(input word_cmd_t c);
    int unsigned       w;
    int unsigned       n;
    int                d;
    int                sel;
    logic [DATA_W-1:0] m;
    logic [DATA_W-1:0] v;
    logic [DATA_W-1:0] sign;
    logic [DATA_W-1:0] cur;
    logic [DATA_W-1:0] r;
    logic [STATUS_W-1:0] st;
    pwa_result_t       res;
    w    = 8 << wcode_q;
    m    = mask_of(w);
    v    = acc_q & m;
    sign = 64'd1 << (w - 1);
    st   = ST_OK;
    case (c.req)
      REQ_DIGIT: begin
        if (c.ch >= "0" && c.ch <= "9") d = int'(c.ch - "0");
        else if (c.ch >= "A" && c.ch <= "F") d = int'(c.ch - "A") + 10;
        else if (c.ch >= "a" && c.ch <= "f") d = int'(c.ch - "a") + 10;
        else d = -1;
        if (d < 0 || d >= int'(base_q)) begin
          st = ST_BAD_DIGIT;
        end else begin
          cur = fresh_q ? 64'd0 : v;
          // The entry overflows when one more digit would not fit in the width.
          if (cur > (m - 64'(d)) / 64'(base_q)) begin
            ovf_q = 1'b1;
            st    = ST_ENTRY_OVF;
          end else begin
            acc_q   = cur * 64'(base_q) + 64'(d);
            fresh_q = 1'b0;
            carry_q = 1'b0;
            ovf_q   = 1'b0;
          end
        end
      end
      REQ_DELETE: begin
        if (!fresh_q && base_q != '0) acc_q = v / 64'(base_q);
      end
      REQ_CLEAR: begin
        acc_q    = '0;
        left_q   = '0;
        pend_q   = LOP_NONE;
        fresh_q  = 1'b1;
        cursor_q = '0;
        carry_q  = 1'b0;
        ovf_q    = 1'b0;
      end
      REQ_LOAD: begin
        carry_q = 1'b0;
        ovf_q   = 1'b0;
        settle(c.load, m);
      end
      REQ_WIDTH: begin
        if (c.wreq inside {7'd8, 7'd16, 7'd32, 7'd64} && int'(c.wreq) <= MAX_WIDTH) begin
          case (c.wreq)
            7'd8:    wcode_q = 2'd0;
            7'd16:   wcode_q = 2'd1;
            7'd32:   wcode_q = 2'd2;
            default: wcode_q = 2'd3;
          endcase
          if (7'(cursor_q) >= c.wreq) cursor_q = CUR_W'(c.wreq - 7'd1);
          acc_q   = acc_q & mask_of(c.wreq);
          left_q  = left_q & mask_of(c.wreq);
          carry_q = 1'b0;
          ovf_q   = 1'b0;
        end else begin
          st = ST_BAD_WIDTH;
        end
      end
      REQ_CURSOR: begin
        sel = int'(cursor_q) + int'($signed(c.mv));
        if (sel < 0) sel = 0;
        if (sel >= int'(w)) sel = int'(w) - 1;
        cursor_q = CUR_W'(sel);
      end
      REQ_SETOP: begin
        left_q  = v;
        pend_q  = c.lop;
        acc_q   = '0;
        fresh_q = 1'b1;
      end
      REQ_EQUALS: begin
        if (pend_q == LOP_NONE) begin
          st = ST_NO_OP;
        end else begin
          case (pend_q)
            LOP_AND: r = left_q & v;
            LOP_OR:  r = left_q | v;
            default: r = left_q ^ v;
          endcase
          carry_q = 1'b0;
          ovf_q   = 1'b0;
          pend_q  = LOP_NONE;
          settle(r, m);
        end
      end
      REQ_SHL: begin
        carry_q = (v & sign) != '0;
        ovf_q   = 1'b0;
        settle(v << 1, m);
      end
      REQ_SHR: begin
        carry_q = v[0];
        ovf_q   = 1'b0;
        settle(v >> 1, m);
      end
      REQ_NOT: begin
        carry_q = 1'b0;
        ovf_q   = 1'b0;
        settle(~v, m);
      end
      REQ_NEG: begin
        carry_q = v != '0;
        ovf_q   = v == sign;
        settle(~v + 64'd1, m);
      end
      REQ_ROL: begin
        carry_q = (v & sign) != '0;
        ovf_q   = 1'b0;
        settle((v << 1) | 64'(carry_q), m);
      end
      REQ_ROR: begin
        carry_q = v[0];
        ovf_q   = 1'b0;
        settle((v >> 1) | (carry_q ? sign : 64'd0), m);
      end
      REQ_SWAP: begin
        n = w / 8;
        r = '0;
        for (int unsigned i = 0; i < n; i++) begin
          r |= ((v >> (8 * i)) & 64'hFF) << (8 * (n - 1 - i));
        end
        carry_q = 1'b0;
        ovf_q   = 1'b0;
        settle(r, m);
      end
      REQ_INC: begin
        carry_q = v == m;
        ovf_q   = v == sign - 64'd1;
        settle(v + 64'd1, m);
      end
      REQ_DEC: begin
        carry_q = v != '0;
        ovf_q   = v == sign;
        settle(v - 64'd1, m);
      end
      REQ_SETBIT: begin
        carry_q = 1'b0;
        ovf_q   = 1'b0;
        settle(v | (64'd1 << cursor_q), m);
      end
      REQ_CLRBIT: begin
        carry_q = 1'b0;
        ovf_q   = 1'b0;
        settle(v & ~(64'd1 << cursor_q), m);
      end
      REQ_TGLBIT: begin
        carry_q = 1'b0;
        ovf_q   = 1'b0;
        settle(v ^ (64'd1 << cursor_q), m);
      end
      REQ_CLRFLAG: begin
        carry_q = 1'b0;
        ovf_q   = 1'b0;
      end
      default: begin
        // Codes above the last command leave everything as it is.
      end
    endcase
    res.acc_value     = acc_q;
    res.carry_flag    = carry_q;
    res.overflow_flag = ovf_q;
    res.status        = st;
    res.cursor_bit    = acc_q[cursor_q];
    res.cursor_index  = cursor_q;
    res.op_pending    = pend_q;
    res.width_bits    = WBITS_W'(8 << wcode_q);
    res.entry_fresh   = fresh_q;
    return res;
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  // Input side: a new beat goes up only once the previous one was taken at the last rising edge.
  always @(negedge clk) begin : drive_commands
    word_cmd_t nxt;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || beat_taken) begin
      if (drain_hold && open_commands != command_fifo.size()) begin
        // Hold back until every report of the beats already sent is back.
        s_axis_tvalid <= 1'b0;
      end else begin
        drain_hold = 1'b0;
        if (command_fifo.size() == 0 || $urandom_range(0, 99) < send_idle_pct) begin
          s_axis_tvalid <= 1'b0;
        end else begin
          nxt = command_fifo.pop_front();
          cmd_on_bus    <= nxt;
          s_axis_tdata  <= {7'd0, nxt.lop, nxt.wreq, nxt.mv, nxt.load, nxt.ch};
          s_axis_tuser  <= nxt.req;
          s_axis_tvalid <= 1'b1;
          if ($urandom_range(0, 249) == 0) drain_hold = 1'b1;
        end
      end
    end
  end

  // Output side back-pressure.
  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Predicts on every accepted command beat and checks every accepted report beat.
  always @(posedge clk) begin : watch_beats
    pwa_result_t got;
    pwa_result_t want;
    if (rst) begin
      beat_taken <= 1'b0;
    end else begin
      beat_taken <= s_axis_tvalid && s_axis_tready;
      if (s_axis_tvalid && s_axis_tready) report_fifo.push_back(apply_command(cmd_on_bus));
      if (m_axis_tvalid && m_axis_tready) begin
        got = pwa_result_t'(m_axis_tdata[85:0]);
        if (report_fifo.size() == 0) begin
          $display("%0t: report beat with nothing expected, expected none, actual %0h",
                   $time, m_axis_tdata);
          fail_count++;
        end else begin
          want = report_fifo.pop_front();
          open_commands--;
          check_field("acc_value", want.acc_value, got.acc_value);
          check_field("carry_flag", 64'(want.carry_flag), 64'(got.carry_flag));
          check_field("overflow_flag", 64'(want.overflow_flag), 64'(got.overflow_flag));
          check_field("status", 64'(want.status), 64'(got.status));
          check_field("cursor_bit", 64'(want.cursor_bit), 64'(got.cursor_bit));
          check_field("cursor_index", 64'(want.cursor_index), 64'(got.cursor_index));
          check_field("op_pending", 64'(want.op_pending), 64'(got.op_pending));
          check_field("width_bits", 64'(want.width_bits), 64'(got.width_bits));
          check_field("entry_fresh", 64'(want.entry_fresh), 64'(got.entry_fresh));
        end
      end
    end
  end

  function automatic void queue_command(input word_cmd_t c);
    command_fifo.push_back(c);
    open_commands++;
    commands_queued++;
  endfunction

  // Operand words lean toward the values where flags and masking change.
  function automatic logic [DATA_W-1:0] random_word();
    case ($urandom_range(0, 6))
      0:       return '0;
      1:       return '1;
      2:       return 64'd1 << $urandom_range(0, 63);
      3:       return (64'd1 << $urandom_range(0, 63)) - 64'd1;
      4:       return ~(64'd1 << $urandom_range(0, 63));
      5:       return 64'($urandom_range(0, 300));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // A character that is a legal digit in the given radix, in either letter case; any byte for radix zero.
  function automatic logic [7:0] legal_digit(input int unsigned base);
    int unsigned val;
    if (base == 0) return 8'($urandom_range(0, 255));
    val = $urandom_range(0, ((base > 16) ? 16 : base) - 1);
    if (val < 10) return 8'("0" + val);
    return 8'((($urandom_range(0, 1) == 0) ? "A" : "a") + val - 10);
  endfunction

  // Fills every field; the caller usually overrides the command code.
  function automatic word_cmd_t random_fields(input int unsigned base);
    word_cmd_t c;
    if ($urandom_range(0, 19) == 0) c.req = REQ_W'($urandom_range(21, 31));
    else c.req = REQ_W'($urandom_range(0, 20));
    c.ch   = ($urandom_range(0, 9) < 7) ? legal_digit(base) : 8'($urandom_range(0, 255));
    c.load = random_word();
    if ($urandom_range(0, 9) == 0) c.mv = 8'($urandom_range(0, 255));
    else c.mv = 8'(int'($urandom_range(0, 128)) - 64);
    case ($urandom_range(0, 9))
      0:       c.wreq = 7'd8;
      1:       c.wreq = 7'd16;
      2:       c.wreq = 7'd32;
      3, 4:    c.wreq = 7'd64;
      5, 6:    c.wreq = 7'd8;
      default: c.wreq = 7'($urandom_range(0, 127));
    endcase
    c.lop = 2'($urandom_range(0, 3));
    return c;
  endfunction

  function automatic void queue_op(input logic [REQ_W-1:0] req, input int unsigned base);
    word_cmd_t c;
    c     = random_fields(base);
    c.req = req;
    queue_command(c);
  endfunction

  // A run of digits, now and then with a stray character or a delete mixed in.
  function automatic void queue_number(input int unsigned base);
    word_cmd_t c;
    int unsigned len;
    len = $urandom_range(1, 22);
    for (int unsigned i = 0; i < len; i++) begin
      c     = random_fields(base);
      c.req = REQ_DIGIT;
      c.ch  = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(0, 255)) : legal_digit(base);
      if ($urandom_range(0, 11) == 0) c.req = REQ_DELETE;
      queue_command(c);
    end
  endfunction

  function automatic void queue_operand(input int unsigned base);
    if ($urandom_range(0, 1) == 0) queue_op(REQ_LOAD, base);
    else queue_number(base);
  endfunction

  // One random stretch of stimulus, mostly well-formed sequences with random content.
  function automatic void queue_burst(input int unsigned base);
    word_cmd_t c;
    int unsigned len;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        queue_command(random_fields(base));
      end
      3, 4: begin
        queue_number(base);
      end
      5, 6, 7: begin
        // Two operands joined by a pending logic operation, then equals.
        queue_operand(base);
        queue_op(REQ_SETOP, base);
        queue_operand(base);
        queue_op(REQ_EQUALS, base);
        if ($urandom_range(0, 4) == 0) queue_op(REQ_EQUALS, base);
      end
      default: begin
        // Pick a width, load a word, then a string of word, logic and bit operations around the cursor.
        c      = random_fields(base);
        c.req  = REQ_WIDTH;
        c.wreq = 7'(8 << $urandom_range(0, 3));
        queue_command(c);
        queue_op(REQ_LOAD, base);
        len = $urandom_range(2, 10);
        for (int unsigned i = 0; i < len; i++) begin
          queue_op(REQ_W'($urandom_range(REQ_CURSOR, REQ_CLRFLAG)), base);
        end
      end
    endcase
  endfunction

  function automatic void queue_directed(input logic [REQ_W-1:0] req, input logic [7:0] ch,
                                         input logic [DATA_W-1:0] load,
                                         input logic signed [7:0] mv,
                                         input logic [WBITS_W-1:0] wreq, input logic [1:0] lop);
    word_cmd_t c;
    c.req  = req;
    c.ch   = ch;
    c.load = load;
    c.mv   = mv;
    c.wreq = wreq;
    c.lop  = lop;
    queue_command(c);
  endfunction

  // The register only changes while nothing is in flight.
  task automatic write_base(input logic [BASE_W-1:0] b);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= b;
    do @(posedge clk); while (!cfg_ready);
    base_q = b;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_for_reports();
    do @(negedge clk); while (open_commands != 0);
  endtask

  initial begin : run_phases
    logic [BASE_W-1:0] phase_base[8];
    int unsigned       c;
    phase_base = '{5'd16, 5'd2, 5'd10, 5'd0, 5'd16, 5'd31, 5'd2, 5'd1};

    // Power-on state of the shadow model.
    c = 0;
    while (c < 3 && (8 << (c + 1)) <= MAX_WIDTH) c++;
    wcode_q  = 2'(c);
    acc_q    = '0;
    left_q   = '0;
    pend_q   = LOP_NONE;
    fresh_q  = 1'b1;
    cursor_q = '0;
    carry_q  = 1'b0;
    ovf_q    = 1'b0;
    base_q   = BASE_RESET;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed pass at the reset radix of ten.
    queue_directed(REQ_WIDTH,   "0", '0, 8'sd0, 7'd7, LOP_NONE);   // rejected width
    queue_directed(REQ_WIDTH,   "0", '0, 8'sd0, 7'd8, LOP_NONE);
    queue_directed(REQ_DIGIT,   "9", '0, 8'sd0, 7'd0, LOP_NONE);
    queue_directed(REQ_DIGIT,   "9", '0, 8'sd0, 7'd0, LOP_NONE);
    queue_directed(REQ_DIGIT,   "9", '0, 8'sd0, 7'd0, LOP_NONE);   // 999 does not fit in 8 bits
    queue_directed(REQ_DIGIT,   "a", '0, 8'sd0, 7'd0, LOP_NONE);   // not below the radix
    queue_directed(REQ_DIGIT,   8'hFF, '0, 8'sd0, 7'd0, LOP_NONE); // not a hex character
    queue_directed(REQ_DELETE,  "0", '0, 8'sd0, 7'd0, LOP_NONE);
    queue_directed(REQ_CLEAR,   "0", '0, 8'sd0, 7'd0, LOP_NONE);
    queue_directed(REQ_DELETE,  "0", '0, 8'sd0, 7'd0, LOP_NONE);   // fresh entry, no change
    queue_directed(REQ_LOAD,    "0", '1, 8'sd0, 7'd0, LOP_NONE);
    queue_directed(REQ_INC,     "0", '0, 8'sd0, 7'd0, LOP_NONE);
    queue_directed(REQ_DEC,     "0", '0, 8'sd0, 7'd0, LOP_NONE);
    queue_directed(REQ_LOAD,    "0", 64'h80, 8'sd0, 7'd0, LOP_NONE);
    queue_directed(REQ_NEG,     "0", '0, 8'sd0, 7'd0, LOP_NONE);
    queue_directed(REQ_CURSOR,  "0", '0, 8'sd64, 7'd0, LOP_NONE);  // clamps to the top bit
    queue_directed(REQ_SETBIT,  "0", '0, 8'sd0, 7'd0, LOP_NONE);
    queue_directed(REQ_TGLBIT,  "0", '0, 8'sd0, 7'd0, LOP_NONE);
    queue_directed(REQ_CLRBIT,  "0", '0, 8'sd0, 7'd0, LOP_NONE);
    queue_directed(REQ_LOAD,    "0", 64'hA5, 8'sd0, 7'd0, LOP_NONE);
    queue_directed(REQ_SHL,     "0", '0, 8'sd0, 7'd0, LOP_NONE);
    queue_directed(REQ_SHR,     "0", '0, 8'sd0, 7'd0, LOP_NONE);
    queue_directed(REQ_ROL,     "0", '0, 8'sd0, 7'd0, LOP_NONE);
    queue_directed(REQ_ROR,     "0", '0, 8'sd0, 7'd0, LOP_NONE);
    queue_directed(REQ_NOT,     "0", '0, 8'sd0, 7'd0, LOP_NONE);
    queue_directed(REQ_WIDTH,   "0", '0, 8'sd0, 7'd64, LOP_NONE);
    queue_directed(REQ_LOAD,    "0", 64'h0123_4567_89AB_CDEF, -8'sd64, 7'd0, LOP_NONE);
    queue_directed(REQ_SWAP,    "0", '0, 8'sd0, 7'd0, LOP_NONE);
    queue_directed(REQ_SETOP,   "0", '0, 8'sd0, 7'd0, LOP_NONE);   // operand taken, nothing pending
    queue_directed(REQ_EQUALS,  "0", '0, 8'sd0, 7'd0, LOP_NONE);   // no pending operation
    queue_directed(REQ_CLRFLAG, "0", '0, 8'sd0, 7'd0, LOP_NONE);
    queue_directed(5'd31,       "0", '0, 8'sd0, 7'd0, LOP_NONE);   // unused command code

    // Random phases: each drains, sets a new radix, then runs with the idling pattern of its group.
    for (int p = 0; p < 8; p++) begin
      wait_for_reports();
      write_base(phase_base[p]);
      if (p < 3) begin
        send_idle_pct = 6;
        recv_idle_pct = 55;
      end else if (p < 6) begin
        send_idle_pct = 55;
        recv_idle_pct = 6;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      commands_queued = 0;
      while (commands_queued < PHASE_ITEMS) queue_burst(phase_base[p]);
    end

    wait_for_reports();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && report_fifo.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
